@@ hdl/swm_pkg.sv @@
// swm_pkg: shared constants, command and status codes and the cell control
// struct of the sorted window median block. Depends on nothing.
package swm_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 64;
	localparam int COUNT_FIELD_W = 7;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} status_t;

	// Broadcast from the control to every cell of the chain.
	typedef struct packed {
		logic                    ins;
		logic                    rem;
		logic signed [VAL_W-1:0] value;
	} cell_ctrl_t;

endpackage

@@ hdl/swm_cell.sv @@
// swm_cell: one slot of the descending sorted chain; compares the broadcast
// value with its own and shifts toward either neighbor. Uses swm_pkg.
module swm_cell (
	input  logic                            clk,
	input  swm_pkg::cell_ctrl_t             ctrl,
	input  logic                            valid,
	input  logic                            left_take,
	input  logic signed [swm_pkg::VAL_W-1:0] left_val,
	input  logic signed [swm_pkg::VAL_W-1:0] right_val,
	output logic                            take,
	output logic                            eq,
	output logic signed [swm_pkg::VAL_W-1:0] val
);
	import swm_pkg::*;

	logic signed [VAL_W-1:0] val_q;
	logic                    del;

	// Empty slots always take, so the take pattern is monotone along the chain.
	assign take = !valid || (ctrl.value >= val_q);
	assign eq   = valid && (val_q == ctrl.value);
	assign del  = !(val_q > ctrl.value);
	assign val  = val_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_take) begin
				val_q <= left_val;
			end else if (take) begin
				val_q <= ctrl.value;
			end
		end else if (ctrl.rem && del) begin
			val_q <= right_val;
		end
	end

endmodule

@@ hdl/sorted_window_median.sv @@
// sorted_window_median: top level; command decode, held count, chain of
// swm_cell slots and median select. Uses swm_pkg and swm_cell.
//
// Usage: beats arrive on the input channel (in_valid/in_ready) carrying cmd
// and value; each accepted beat yields exactly one result beat on the
// output channel (out_valid/out_ready) with median, count, empty_res and
// status. Insert places value ahead of the first held value it is greater
// than or equal to; remove drops the first equal value and closes the gap;
// clear empties the store. A failed insert (full) or remove (absent) leaves
// the store unchanged and reports it in status.
//
// Timing: the chain updates at the edge that accepts a beat, since every
// cell compares the broadcast value at once. The select state that follows
// moves the median from the updated cells into the output register and
// raises out_valid, so no new beat is taken until that select is done.
// in_ready drops for that select state. While a result waits in the output
// register the next beat is still accepted; its select cycle then holds, with
// in_ready low, until the receiver takes the pending one.
//
// Reset: arst_n clears the held count and the handshake state; the cell
// contents are undefined until written and never read beyond the count.
module sorted_window_median (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      cmd,
	input  logic signed [swm_pkg::VAL_W-1:0] value,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [swm_pkg::VAL_W-1:0] median,
	output logic [swm_pkg::COUNT_FIELD_W-1:0] count,
	output logic                            empty_res,
	output logic [1:0]                      status
);
	import swm_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_SEL
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        cnt_q;
	status_t                 status_q;
	logic                    out_valid_q;
	logic signed [VAL_W-1:0] median_q;
	logic [COUNT_FIELD_W-1:0] count_q;
	logic                    empty_q;
	status_t                 status_out_q;

	logic                    accept;
	logic                    full;
	logic                    found;
	logic                    load_out;
	cell_ctrl_t              ctrl;
	logic [IDX_W-1:0]        mid;
	logic signed [VAL_W-1:0] sel_val;

	logic signed [VAL_W-1:0] val_arr  [DEPTH];
	logic                    take_arr [DEPTH];
	logic [DEPTH-1:0]        eq_vec;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign found    = |eq_vec;

	assign ctrl.ins   = accept && (cmd == CMD_INSERT) && !full;
	assign ctrl.rem   = accept && (cmd == CMD_REMOVE) && found;
	assign ctrl.value = value;

	// Chain of cells: take flags ripple left to right for insert, values
	// move one slot right on insert or one slot left on remove.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(i);
		logic                    l_take;
		logic signed [VAL_W-1:0] l_val;
		logic signed [VAL_W-1:0] r_val;
		logic                    eq_i;

		if (i == 0) begin : g_head
			assign l_take = 1'b0;
			assign l_val  = value;
		end else begin : g_body
			assign l_take = take_arr[i-1];
			assign l_val  = val_arr[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign r_val = val_arr[i];
		end else begin : g_mid
			assign r_val = val_arr[i+1];
		end

		swm_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.valid     (POS < cnt_q),
			.left_take (l_take),
			.left_val  (l_val),
			.right_val (r_val),
			.take      (take_arr[i]),
			.eq        (eq_i),
			.val       (val_arr[i])
		);
		assign eq_vec[i] = eq_i;
	end

	// Median sits at slot count/2 of the descending chain.
	assign mid = IDX_W'(cnt_q >> 1);

	always_comb begin
		sel_val = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (mid == IDX_W'(k)) begin
				sel_val = sel_val | val_arr[k];
			end
		end
	end

	assign load_out = (state_q == ST_SEL) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			status_q    <= STAT_OK;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					// Drop the result once the receiver takes it.
					if (out_valid_q && out_ready) begin
						out_valid_q <= 1'b0;
					end
					if (accept) begin
						state_q <= ST_SEL;
						unique case (cmd)
							CMD_INSERT: begin
								if (full) begin
									status_q <= STAT_FULL;
								end else begin
									status_q <= STAT_OK;
									cnt_q    <= cnt_q + 1'b1;
								end
							end
							CMD_REMOVE: begin
								if (found) begin
									status_q <= STAT_OK;
									cnt_q    <= cnt_q - 1'b1;
								end else begin
									status_q <= STAT_NOT_FOUND;
								end
							end
							CMD_CLEAR: begin
								status_q <= STAT_OK;
								cnt_q    <= '0;
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				ST_SEL: begin
					// Hold here while the previous result still waits.
					if (load_out) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output payload, loaded together with out_valid.
	always_ff @(posedge clk) begin
		if (load_out) begin
			median_q     <= (cnt_q == '0) ? '0 : sel_val;
			count_q      <= COUNT_FIELD_W'(cnt_q);
			empty_q      <= (cnt_q == '0);
			status_out_q <= status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign count     = count_q;
	assign empty_res = empty_q;
	assign status    = status_out_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("held count beyond depth");

	a_accept_sel: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SEL))
		else $error("accepted beat did not move to select");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_CLEAR) |=> (cnt_q == '0))
		else $error("clear did not empty the store");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_INSERT && full) |=> (status_q == STAT_FULL && $stable(cnt_q)))
		else $error("insert into full store changed the count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (empty_q == (count_q == '0)))
		else $error("empty flag disagrees with count");

endmodule

@@ test/swm_median_checker.sv @@
// swm_median_checker: watches both channels of sorted_window_median, keeps its
// own sorted store to predict each result beat and compares field by field.
// Depends on swm_pkg.
module swm_median_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [1:0]                        cmd,
	input  logic signed [swm_pkg::VAL_W-1:0]  value,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [swm_pkg::VAL_W-1:0]  median,
	input  logic [swm_pkg::COUNT_FIELD_W-1:0] count,
	input  logic                              empty_res,
	input  logic [1:0]                        status,
	output int                                fail_count,
	output int                                pending
);
	import swm_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0]  median;
		logic [COUNT_FIELD_W-1:0] count;
		logic                     empty;
		status_t                  status;
	} median_beat_t;

	// Descending store and its fill level; entries at or above held_num are never read.
	logic signed [VAL_W-1:0] held_vals [DEPTH];
	int                      held_num;
	median_beat_t            median_due [$];
	int                      fails = 0;

	assign fail_count = fails;

	task automatic report_mismatch(input string msg);
		if (fails < 40)
			$display("%0t mismatch: %s", $realtime, msg);
		fails++;
	endtask

	// Apply one command beat to the store and return the result it must produce.
	function automatic median_beat_t apply_command(input logic [1:0] c,
			input logic signed [VAL_W-1:0] v);
		median_beat_t r;
		int           pos;
		int           i;
		r.status = STAT_OK;
		case (c)
			CMD_INSERT: begin
				if (held_num >= DEPTH)
					r.status = STAT_FULL;
				else begin
					pos = held_num;
					for (i = 0; i < held_num; i++)
						if (v >= held_vals[i]) begin
							pos = i;
							break;
						end
					for (i = held_num; i > pos; i--)
						held_vals[i] = held_vals[i-1];
					held_vals[pos] = v;
					held_num++;
				end
			end
			CMD_REMOVE: begin
				pos = -1;
				for (i = 0; i < held_num; i++)
					if (held_vals[i] == v) begin
						pos = i;
						break;
					end
				if (pos < 0)
					r.status = STAT_NOT_FOUND;
				else begin
					for (i = pos; i + 1 < held_num; i++)
						held_vals[i] = held_vals[i+1];
					held_num--;
				end
			end
			CMD_CLEAR: held_num = 0;
			default: ;
		endcase
		r.empty  = (held_num == 0);
		r.median = (held_num == 0) ? '0 : held_vals[held_num / 2];
		r.count  = held_num[COUNT_FIELD_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		median_beat_t want;
		if (!arst_n) begin
			held_num = 0;
			median_due.delete();
			pending = 0;
		end else begin
			// Check the leaving beat first: its expectation is always older.
			if (out_valid && out_ready) begin
				if (median_due.size() == 0)
					report_mismatch("result beat with nothing expected");
				else begin
					want = median_due.pop_front();
					if (median !== want.median)
						report_mismatch($sformatf("median got %0d want %0d",
							median, want.median));
					if (count !== want.count)
						report_mismatch($sformatf("count got %0d want %0d",
							count, want.count));
					if (empty_res !== want.empty)
						report_mismatch($sformatf("empty_res got %b want %b",
							empty_res, want.empty));
					if (status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							status, want.status));
				end
			end
			if (in_valid && in_ready)
				median_due.push_back(apply_command(cmd, value));
			pending = median_due.size();
		end
	end

endmodule

@@ test/tb_sorted_window_median.sv @@
// tb_sorted_window_median: stimulus and verdict for sorted_window_median; the
// checker module predicts and compares. Depends on swm_pkg, the block, swm_median_checker.
module tb_sorted_window_median;
	import swm_pkg::*;

	localparam int ITEM_GOAL   = 1650;
	localparam int CALM_TAIL   = 150;  // last items run with no idling on either side
	localparam int HOLD_CYCLES = 60;   // long receiver hold-off
	localparam int POOL_N      = 16;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [1:0]               cmd       = CMD_CLEAR;
	logic signed [VAL_W-1:0]  value     = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [VAL_W-1:0]  median;
	logic [COUNT_FIELD_W-1:0] count;
	logic                     empty_res;
	logic [1:0]               status;
	int                       fail_count;
	int                       pending;

	// Handshakes between the stimulus and the receiver process.
	bit                       calm      = 1'b0;
	bit                       hold_req  = 1'b0;
	bit                       hold_done = 1'b0;
	int                       beats_sent = 0;
	logic signed [VAL_W-1:0]  value_pool [POOL_N];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	sorted_window_median u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.median    (median),
		.count     (count),
		.empty_res (empty_res),
		.status    (status)
	);

	swm_median_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.median     (median),
		.count      (count),
		.empty_res  (empty_res),
		.status     (status),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Offer one beat and hold it until the block takes it. Called at a rising
	// edge; valid stays high afterwards so back-to-back beats need no toggle.
	task automatic send_beat(input cmd_t c, input logic signed [VAL_W-1:0] v);
		in_valid <= 1'b1;
		cmd      <= c;
		value    <= v;
		do
			@(posedge clk);
		while (!in_ready);
		beats_sent++;
	endtask

	// Drop valid for an idle gap of length n.
	task automatic idle_gap(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Stop offering and wait until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
	endtask

	// Mostly pool values so removes hit and duplicates pile up; the rest is
	// fully random so every value bit toggles.
	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 9) < 3)
			return {$urandom, $urandom};
		return value_pool[$urandom_range(0, POOL_N - 1)];
	endfunction

	// Random gap on the sender side between beats, none in the calm tail.
	task automatic maybe_gap();
		if (!calm && $urandom_range(0, 4) == 0)
			idle_gap($urandom_range(1, 11));
	endtask

	// Receiver: random ready bursts and stalls, one long hold-off on request,
	// steady ready in the calm tail.
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (calm) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	// Give up if the run hangs.
	initial begin
		#2000000;
		$display("FAIL sorted_window_median");
		$finish;
	end

	initial begin
		int   phase;
		int   plen;
		int   k;
		int   roll;
		bit   first_phase;
		bit   hold_used;
		cmd_t c;

		value_pool[0] = 64'sh7FFF_FFFF_FFFF_FFFF;
		value_pool[1] = 64'sh8000_0000_0000_0000;
		value_pool[2] = '0;
		value_pool[3] = -64'sd1;
		value_pool[4] = 64'sd1;
		for (k = 5; k < POOL_N; k++)
			value_pool[k] = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom}
				: $signed(64'($urandom_range(0, 40))) - 64'sd20;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty-store cases, extremes, duplicates at head and tail,
		// absent removes, clear, and draining back to empty.
		send_beat(CMD_REMOVE, '0);
		send_beat(CMD_CLEAR,  '0);
		send_beat(CMD_INSERT, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_beat(CMD_INSERT, 64'sh8000_0000_0000_0000);
		send_beat(CMD_INSERT, '0);
		send_beat(CMD_INSERT, -64'sd1);
		send_beat(CMD_INSERT, '0);
		send_beat(CMD_INSERT, 64'sd1);
		send_beat(CMD_INSERT, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_beat(CMD_INSERT, 64'sh8000_0000_0000_0000);
		send_beat(CMD_REMOVE, '0);
		send_beat(CMD_REMOVE, 64'sd12345);
		send_beat(CMD_REMOVE, 64'sh8000_0000_0000_0000);
		send_beat(CMD_REMOVE, 64'sh7FFF_FFFF_FFFF_FFFF);
		send_beat(CMD_INSERT, 64'sh5555_5555_5555_5555);
		send_beat(CMD_INSERT, 64'shAAAA_AAAA_AAAA_AAAA);
		send_beat(CMD_CLEAR,  '0);
		send_beat(CMD_INSERT, -64'sd1);
		send_beat(CMD_REMOVE, -64'sd1);
		send_beat(CMD_REMOVE, -64'sd1);

		// Pause the sender until every result is back.
		drain_results();

		// Random part in phases. Fill: clear then overflow the store. Grow and
		// shrink bias toward insert or remove so the count sweeps its range.
		first_phase = 1'b1;
		hold_used   = 1'b0;
		beats_sent  = 0;
		while (beats_sent < ITEM_GOAL) begin
			phase = first_phase ? 0 : $urandom_range(0, 5);
			first_phase = 1'b0;
			if (phase == 0) begin
				send_beat(CMD_CLEAR, pick_value());
				maybe_gap();
				for (k = 0; k < DEPTH + 2; k++) begin
					send_beat(CMD_INSERT, pick_value());
					maybe_gap();
				end
			end else begin
				plen = $urandom_range(20, 120);
				for (k = 0; k < plen; k++) begin
					roll = $urandom_range(0, 99);
					if (roll < 1)
						c = CMD_CLEAR;
					else if (phase <= 2)
						c = (roll < 75) ? CMD_INSERT : CMD_REMOVE;
					else if (phase <= 4)
						c = (roll < 75) ? CMD_REMOVE : CMD_INSERT;
					else
						c = (roll < 50) ? CMD_INSERT : CMD_REMOVE;
					send_beat(c, pick_value());
					maybe_gap();
				end
			end

			// Once, midway: hold the receiver off while beats keep coming so
			// the block fills and stalls its input.
			if (!hold_used && beats_sent > ITEM_GOAL / 3) begin
				hold_used = 1'b1;
				hold_req  = 1'b1;
				for (k = 0; k < 20; k++)
					send_beat(CMD_INSERT, pick_value());
				wait (hold_done);
				hold_req = 1'b0;
				drain_results();
			end

			if (beats_sent >= ITEM_GOAL - CALM_TAIL)
				calm = 1'b1;
		end

		// Let everything drain, then give the verdict.
		drain_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("PASS sorted_window_median");
		else
			$display("FAIL sorted_window_median");
		$finish;
	end

endmodule
